// ===== design/xcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// xcfd_pkg: shared types and constants of the XOR-checked frame deframer
// Result kinds, frame byte codes, register map and the command type that
// travels from the frame parser to the result stage.
// ----------------------------------------------------------------------------
package xcfd_pkg;

  // result kinds
  localparam logic [2:0] KIND_ALIVE      = 3'd0;
  localparam logic [2:0] KIND_TWO_PLAYER = 3'd1;
  localparam logic [2:0] KIND_SELECT_JOY = 3'd2;
  localparam logic [2:0] KIND_KEY        = 3'd3;
  localparam logic [2:0] KIND_DATA       = 3'd4;
  localparam logic [2:0] KIND_LINK_LOST  = 3'd5;

  // byte codes on the link
  localparam logic [7:0] START_CODE      = 8'hAA;
  localparam logic [7:0] DATA_CODE       = 8'h33;
  localparam logic [7:0] STOP_CODE       = 8'h55;
  localparam logic [7:0] ALIVE_CODE      = 8'hFF;
  localparam logic [7:0] TWO_PLAYER_CODE = 8'hFE;
  localparam logic [7:0] SELECT_JOY_CODE = 8'hFD;

  // register map (word index)
  localparam logic [0:0] REG_FORWARD_KEYS = 1'b0;

  // fixed frame positions
  localparam int POS_KEY_STOP   = 4;
  localparam int POS_DATA_FIRST = 5;

  // command queue between parser and result stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] key_type;
    logic [7:0] key_code;
  } cmd_t;

endpackage

// ===== design/xcfd_front.sv =====
// ----------------------------------------------------------------------------
// xcfd_front: frame parser
// Takes one item per cycle when not full, tracks the frame position,
// checks key and data frames, fills the payload memory and issues commands.
// ----------------------------------------------------------------------------
module xcfd_front import xcfd_pkg::*; #(
  parameter int PAYLOAD_WORDS = 7,
  localparam int AW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic          in_func,
  input  logic [7:0]    in_rx_byte,
  output logic          full,
  input  logic          forward_keys,
  input  logic          data_done,
  output logic          data_busy,
  input  logic          q_full,
  output logic          cmd_push,
  output cmd_t          cmd,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [31:0]   mem_wdata
);

  localparam int PAYLOAD_BYTES  = 4 * PAYLOAD_WORDS;
  localparam int POS_DATA_CHECK = POS_DATA_FIRST + PAYLOAD_BYTES;
  localparam int POS_DATA_STOP  = POS_DATA_CHECK + 1;
  localparam int PB             = $clog2(POS_DATA_STOP + 1);

  logic [PB-1:0] pos_r, pos_nxt;
  logic          busy_r, busy_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic [7:0]    chk_r, chk_nxt;
  logic [23:0]   sh_r, sh_nxt;
  logic [7:0]    keyb_r [3];
  logic          keyb_we;
  logic [1:0]    key_idx;
  logic [PB-1:0] ofs;
  logic          in_payload;
  logic          word_end;
  logic          acc;
  logic          key_good;

  // payload position decode
  assign ofs        = pos_r - PB'(POS_DATA_FIRST);
  assign in_payload = (pos_r >= PB'(POS_DATA_FIRST)) && (pos_r < PB'(POS_DATA_CHECK));
  assign word_end   = in_payload && (ofs[1:0] == 2'd3);
  assign key_idx    = pos_r[1:0] - 2'd1;
  assign key_good   = (in_rx_byte == STOP_CODE) && ((keyb_r[0] ^ keyb_r[1]) == keyb_r[2]);

  // hold off on a full queue or while the payload memory is still being read out
  assign full      = q_full || (word_end && busy_r);
  assign acc       = push && !full;
  assign data_busy = busy_r;

  assign mem_waddr = ofs[AW+1:2];
  assign mem_wdata = {in_rx_byte, sh_r};

  // parser next state
  always_comb begin
    pos_nxt  = pos_r;
    xor_nxt  = xor_r;
    chk_nxt  = chk_r;
    sh_nxt   = sh_r;
    keyb_we  = 1'b0;
    mem_we   = 1'b0;
    cmd_push = 1'b0;
    cmd      = '0;
    if (acc) begin
      if (in_func) begin
        cmd_push = 1'b1;
        cmd.kind = KIND_LINK_LOST;
      end else if (pos_r == '0) begin
        if (in_rx_byte == ALIVE_CODE) begin
          cmd_push = 1'b1;
          cmd.kind = KIND_ALIVE;
        end else if (in_rx_byte == TWO_PLAYER_CODE) begin
          cmd_push = 1'b1;
          cmd.kind = KIND_TWO_PLAYER;
        end else if (in_rx_byte == SELECT_JOY_CODE) begin
          cmd_push = 1'b1;
          cmd.kind = KIND_SELECT_JOY;
        end else if (in_rx_byte == START_CODE) begin
          pos_nxt = PB'(1);
        end else if (in_rx_byte == DATA_CODE) begin
          pos_nxt = PB'(POS_DATA_FIRST);
          xor_nxt = '0;
        end
      end else if (pos_r < PB'(POS_KEY_STOP)) begin
        keyb_we = 1'b1;
        pos_nxt = pos_r + PB'(1);
      end else if (pos_r == PB'(POS_KEY_STOP)) begin
        pos_nxt = '0;
        if (key_good && forward_keys) begin
          cmd_push     = 1'b1;
          cmd.kind     = KIND_KEY;
          cmd.key_type = keyb_r[0];
          cmd.key_code = keyb_r[1];
        end
      end else if (in_payload) begin
        xor_nxt = xor_r ^ in_rx_byte;
        sh_nxt  = {in_rx_byte, sh_r[23:8]};
        mem_we  = word_end;
        pos_nxt = pos_r + PB'(1);
      end else if (pos_r == PB'(POS_DATA_CHECK)) begin
        chk_nxt = in_rx_byte;
        pos_nxt = pos_r + PB'(1);
      end else begin
        pos_nxt = '0;
        if ((in_rx_byte == STOP_CODE) && (xor_r == chk_r)) begin
          cmd_push = 1'b1;
          cmd.kind = KIND_DATA;
        end
      end
    end
  end

  // payload memory in use from data command until its last word is read
  always_comb begin
    busy_nxt = busy_r;
    if (cmd_push && (cmd.kind == KIND_DATA)) begin
      busy_nxt = 1'b1;
    end else if (data_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      busy_r <= busy_nxt;
    end
  end

  // frame bytes
  always_ff @(posedge clk) begin
    xor_r <= xor_nxt;
    chk_r <= chk_nxt;
    sh_r  <= sh_nxt;
    if (keyb_we) begin
      keyb_r[key_idx] <= in_rx_byte;
    end
  end

endmodule

// ===== design/xcfd_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// xcfd_cmd_queue: command queue
// Small first-in first-out store that decouples the parser from the result
// stage.
// ----------------------------------------------------------------------------
module xcfd_cmd_queue import xcfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_en,
  input  cmd_t push_cmd,
  input  logic pop_en,
  output cmd_t head_cmd,
  output logic q_empty,
  output logic q_full
);

  cmd_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  assign q_empty  = (count_r == '0);
  assign q_full   = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_cmd = entry_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push_en && !pop_en) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_en && !push_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_en) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/xcfd_back.sv =====
// ----------------------------------------------------------------------------
// xcfd_back: result stage
// Holds the payload memory, expands commands into result items (one data
// frame word a cycle unless output stalls) and drives the output register.
// ----------------------------------------------------------------------------
module xcfd_back import xcfd_pkg::*; #(
  parameter int PAYLOAD_WORDS = 7,
  localparam int AW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  cmd_t          q_cmd,
  output logic          q_pop,
  input  logic          mem_we,
  input  logic [AW-1:0] mem_waddr,
  input  logic [31:0]   mem_wdata,
  output logic          data_done,
  input  logic          pop,
  output logic          empty,
  output logic [2:0]    out_kind,
  output logic [7:0]    out_key_type,
  output logic [7:0]    out_key_code,
  output logic [31:0]   out_data_word,
  output logic [2:0]    out_word_index,
  output logic          out_last
);

  localparam logic [AW-1:0] LAST_WORD = AW'(PAYLOAD_WORDS - 1);
  localparam logic          ONE_WORD  = (PAYLOAD_WORDS == 1);

  logic [31:0]   mem [PAYLOAD_WORDS];
  logic [31:0]   rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic          active_r, active_nxt;
  logic [AW-1:0] widx_r, widx_nxt;

  logic          p1_valid_r, p1_valid_nxt;
  cmd_t          p1_cmd_r;
  logic [AW-1:0] p1_idx_r;
  logic          p1_last_r;

  logic          issue;
  cmd_t          issue_cmd;
  logic [AW-1:0] issue_idx;
  logic          issue_last;
  logic          issue_ok;
  logic          out_load;
  logic          out_valid_r;
  logic [AW+2:0] idx_wide;

  assign out_load = p1_valid_r && (!out_valid_r || pop);
  assign issue_ok = !p1_valid_r || out_load;
  assign idx_wide = {3'b000, p1_idx_r};

  // issue: one result item a cycle while issue_ok allows, words of a data frame in order
  always_comb begin
    issue      = 1'b0;
    issue_cmd  = '0;
    issue_idx  = '0;
    issue_last = 1'b1;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = widx_r;
    active_nxt = active_r;
    widx_nxt   = widx_r;
    if (active_r) begin
      if (issue_ok) begin
        issue          = 1'b1;
        issue_cmd.kind = KIND_DATA;
        issue_idx      = widx_r;
        issue_last     = (widx_r == LAST_WORD);
        rd_en          = 1'b1;
        widx_nxt       = widx_r + 1'b1;
        active_nxt     = (widx_r != LAST_WORD);
      end
    end else if (!q_empty && issue_ok) begin
      q_pop     = 1'b1;
      issue     = 1'b1;
      issue_cmd = q_cmd;
      if (q_cmd.kind == KIND_DATA) begin
        issue_last = ONE_WORD;
        rd_en      = 1'b1;
        rd_addr    = '0;
        widx_nxt   = AW'(1);
        active_nxt = !ONE_WORD;
      end
    end
  end

  assign data_done = issue && (issue_cmd.kind == KIND_DATA) && issue_last;

  always_comb begin
    p1_valid_nxt = p1_valid_r;
    if (issue) begin
      p1_valid_nxt = 1'b1;
    end else if (out_load) begin
      p1_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      widx_r      <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r   <= active_nxt;
      widx_r     <= widx_nxt;
      p1_valid_r <= p1_valid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // issue stage and output register payload
  always_ff @(posedge clk) begin
    if (issue) begin
      p1_cmd_r  <= issue_cmd;
      p1_idx_r  <= issue_idx;
      p1_last_r <= issue_last;
    end
    if (out_load) begin
      out_kind       <= p1_cmd_r.kind;
      out_key_type   <= p1_cmd_r.key_type;
      out_key_code   <= p1_cmd_r.key_code;
      out_data_word  <= (p1_cmd_r.kind == KIND_DATA) ? rd_data_r : 32'd0;
      out_word_index <= idx_wide[2:0];
      out_last       <= p1_last_r;
    end
  end

  assign empty = !out_valid_r;

endmodule

// ===== design/xor_checked_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer: XOR-checked frame deframer, top level
// Parses received bytes and timeout ticks into control, key and data results.
// ----------------------------------------------------------------------------
// The block takes at most one item per clock cycle. Control codes, timeout
// ticks and good key frames (with forwarding on) give one result; a good
// data frame gives PAYLOAD_WORDS results on its stop byte, which leave the
// result stage one word a cycle while the output is not held, read from the
// payload memory. A four-entry command queue sits between the frame parser
// and the result stage, so input keeps flowing while results wait; full
// rises when that queue is full, or when a data frame is about to write a
// payload word while the previous frame's words are still being read out.
// With results taken every cycle, items flow one a cycle except in two
// cases: a data frame (4*PAYLOAD_WORDS+3 items) that starts right after
// another one waits at its fourth payload byte for the readout to end; and
// items that each give a result and arrive during a readout can fill the
// queue and wait until the readout ends. A result passes from the command
// queue through the issue stage register to the output register.
module xor_checked_frame_deframer import xcfd_pkg::*; #(
  parameter int PAYLOAD_WORDS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic        in_func,
  input  logic [7:0]  in_rx_byte,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_key_type,
  output logic [7:0]  out_key_code,
  output logic [31:0] out_data_word,
  output logic [2:0]  out_word_index,
  output logic        out_last,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;

  logic          forward_keys_r;
  logic          cfg_wr;
  logic          data_done;
  logic          data_busy;
  logic          q_full, q_empty, q_pop;
  logic          cmd_push;
  cmd_t          cmd, q_cmd;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2:2] == REG_FORWARD_KEYS) ? {31'd0, forward_keys_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      forward_keys_r <= 1'b0;
    end else if (cfg_wr && (paddr[2:2] == REG_FORWARD_KEYS)) begin
      forward_keys_r <= pwdata[0];
    end
  end

  xcfd_front #(.PAYLOAD_WORDS(PAYLOAD_WORDS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .in_func      (in_func),
    .in_rx_byte   (in_rx_byte),
    .full         (full),
    .forward_keys (forward_keys_r),
    .data_done    (data_done),
    .data_busy    (data_busy),
    .q_full       (q_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata)
  );

  xcfd_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (cmd_push),
    .push_cmd (cmd),
    .pop_en   (q_pop),
    .head_cmd (q_cmd),
    .q_empty  (q_empty),
    .q_full   (q_full)
  );

  xcfd_back #(.PAYLOAD_WORDS(PAYLOAD_WORDS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .data_done      (data_done),
    .pop            (pop),
    .empty          (empty),
    .out_kind       (out_kind),
    .out_key_type   (out_key_type),
    .out_key_code   (out_key_code),
    .out_data_word  (out_data_word),
    .out_word_index (out_word_index),
    .out_last       (out_last)
  );

  // payload memory is never written while a frame is being read out
  a_no_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !data_busy)
    else $error("payload write while readout busy");

  // the queue never takes a command when full
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !q_full)
    else $error("command pushed into full queue");

  // only data words can be followed by further results of the same item
  a_not_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last) |-> (out_kind == KIND_DATA))
    else $error("non-final result of non-data kind");

  // a finished readout releases the payload memory on the next cycle
  a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
    data_done |=> !data_busy)
    else $error("payload memory still busy after readout");

endmodule

// ===== tb/xor_checked_frame_deframer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer_test: self-checking bench for the frame deframer
// Feeds control codes, timeout ticks, key frames and data frames (good, bad
// check, bad stop, truncated) with random gaps on both sides. A scoreboard
// class tracks the frame state and compares every result field by field.
// ----------------------------------------------------------------------------
module xor_checked_frame_deframer_test;
  import xcfd_pkg::*;

  localparam int PAYLOAD_WORDS = 7;
  localparam int PAYLOAD_BYTES = 4 * PAYLOAD_WORDS;
  localparam int POS_CHECK     = POS_DATA_FIRST + PAYLOAD_BYTES;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 100;
  localparam int SETTLE_CYCLES = 10;
  localparam logic [2:0] FWD_ADDR = 3'(REG_FORWARD_KEYS) << 2;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  key_type;
    logic [7:0]  key_code;
    logic [31:0] data_word;
    logic [2:0]  word_index;
    logic        last;
  } deframe_result_t;

  // Tracks the deframer state and holds the results still owed by the block
  class deframe_tracker;
    bit              forward_keys = 1'b0;
    int              frame_pos = 0;
    logic [7:0]      payload[PAYLOAD_BYTES];
    logic [7:0]      key_bytes[3];
    logic [7:0]      check_byte;
    deframe_result_t awaited[$];
    int              errors = 0;
    int              items_seen = 0;
    int              results_seen = 0;

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    function void owe(logic [2:0] kind, logic [7:0] kt, logic [7:0] kc,
                      logic [31:0] w, logic [2:0] idx, logic last);
      deframe_result_t r;
      r.kind = kind;
      r.key_type = kt;
      r.key_code = kc;
      r.data_word = w;
      r.word_index = idx;
      r.last = last;
      awaited.push_back(r);
    endfunction

    // Advance the frame state by one accepted item
    function void note_item(logic func, logic [7:0] b);
      logic [7:0] x;
      items_seen++;
      if (func) begin
        owe(KIND_LINK_LOST, 0, 0, 0, 0, 1'b1);
      end else if (frame_pos == 0) begin
        case (b)
          ALIVE_CODE:      owe(KIND_ALIVE, 0, 0, 0, 0, 1'b1);
          TWO_PLAYER_CODE: owe(KIND_TWO_PLAYER, 0, 0, 0, 0, 1'b1);
          SELECT_JOY_CODE: owe(KIND_SELECT_JOY, 0, 0, 0, 0, 1'b1);
          START_CODE:      frame_pos = 1;
          DATA_CODE:       frame_pos = POS_DATA_FIRST;
          default:         ;
        endcase
      end else if (frame_pos < POS_KEY_STOP) begin
        key_bytes[frame_pos - 1] = b;
        frame_pos++;
      end else if (frame_pos == POS_KEY_STOP) begin
        frame_pos = 0;
        if (b == STOP_CODE && (key_bytes[0] ^ key_bytes[1]) == key_bytes[2] &&
            forward_keys)
          owe(KIND_KEY, key_bytes[0], key_bytes[1], 0, 0, 1'b1);
      end else if (frame_pos < POS_CHECK) begin
        payload[frame_pos - POS_DATA_FIRST] = b;
        frame_pos++;
      end else if (frame_pos == POS_CHECK) begin
        check_byte = b;
        frame_pos++;
      end else begin
        // data stop byte: release the words only on a clean frame
        frame_pos = 0;
        x = 8'h00;
        foreach (payload[i]) x ^= payload[i];
        if (b == STOP_CODE && x == check_byte)
          for (int i = 0; i < PAYLOAD_WORDS; i++)
            owe(KIND_DATA, 0, 0,
                {payload[4*i+3], payload[4*i+2], payload[4*i+1], payload[4*i]},
                3'(i), (i == PAYLOAD_WORDS - 1));
      end
    endfunction

    task field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", results_seen, name,
                         got, want));
    endtask

    task check_result(deframe_result_t got);
      deframe_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result %0d, kind %0d", results_seen,
                         got.kind));
      end else begin
        want = awaited.pop_front();
        field("kind", got.kind, want.kind);
        field("key_type", got.key_type, want.key_type);
        field("key_code", got.key_code, want.key_code);
        field("data_word", got.data_word, want.data_word);
        field("word_index", got.word_index, want.word_index);
        field("last", got.last, want.last);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_func = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_key_type;
  logic [7:0]  out_key_code;
  logic [31:0] out_data_word;
  logic [2:0]  out_word_index;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  deframe_tracker tracker = new;
  bit no_idle = 1'b0;
  int phase_items = 0;
  int settings_used = 1;
  int idle_cycles = 0;

  xor_checked_frame_deframer #(.PAYLOAD_WORDS(PAYLOAD_WORDS)) uut (.*);

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic [7:0] some_code();
    logic [7:0] codes[6] = '{START_CODE, DATA_CODE, STOP_CODE, ALIVE_CODE,
                             TWO_PLAYER_CODE, SELECT_JOY_CODE};
    return codes[$urandom_range(0, 5)];
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_item(input logic func, input logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_func <= func;
    in_rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.note_item(func, b);
    phase_items++;
  endtask

  // Frame byte with an occasional timeout tick slipped in ahead of it
  task automatic send_frame_byte(input logic [7:0] b);
    if ($urandom_range(0, 24) == 0) send_item(1'b1, 8'($urandom_range(0, 255)));
    send_item(1'b0, b);
  endtask

  task automatic send_key_frame();
    logic [7:0] kt, kc, chk;
    kt = ($urandom_range(0, 4) == 0) ? some_code() : 8'($urandom_range(0, 255));
    kc = 8'($urandom_range(0, 255));
    chk = kt ^ kc;
    if ($urandom_range(0, 3) == 0) chk ^= 8'(1 << $urandom_range(0, 7));
    send_frame_byte(START_CODE);
    send_frame_byte(kt);
    send_frame_byte(kc);
    send_frame_byte(chk);
    send_frame_byte(($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                : STOP_CODE);
  endtask

  task automatic send_data_frame();
    logic [7:0] b, x;
    x = 8'h00;
    send_frame_byte(DATA_CODE);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      b = ($urandom_range(0, 7) == 0) ? some_code() : 8'($urandom_range(0, 255));
      x ^= b;
      send_frame_byte(b);
    end
    if ($urandom_range(0, 4) == 0) x ^= 8'(1 << $urandom_range(0, 7));
    send_frame_byte(x);
    send_frame_byte(($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                : STOP_CODE);
  endtask

  // Mostly well-formed frames, some noise and truncated frames
  task automatic random_phase(input int target);
    int pick, n;
    phase_items = 0;
    while (phase_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_data_frame();
      end else if (pick < 62) begin
        send_key_frame();
      end else if (pick < 77) begin
        send_item(1'b0, 8'(SELECT_JOY_CODE + $urandom_range(0, 2)));
      end else if (pick < 85) begin
        send_item(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        send_item(1'b0, 8'($urandom_range(0, 255)));
      end else begin
        send_item(1'b0, $urandom_range(0, 1) ? START_CODE : DATA_CODE);
        n = $urandom_range(0, 3);
        repeat (n) send_item(1'b0, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Wait until every owed result has come out and the pipeline is quiet
  task automatic settle();
    push <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FWD_ADDR;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    tracker.forward_keys = data[0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= FWD_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[0] !== tracker.forward_keys)
      tracker.report($sformatf("forward_keys reads %0b want %0b", prdata[0],
                               tracker.forward_keys));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random pops, one long hold-off to back the block up
  initial begin
    deframe_result_t r;
    int gap;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && tracker.results_seen == 12) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = draw_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty || !rst_n) @(posedge clk);
      r.kind = out_kind;
      r.key_type = out_key_type;
      r.key_code = out_key_code;
      r.data_word = out_data_word;
      r.word_index = out_word_index;
      r.last = out_last;
      tracker.check_result(r);
    end
  end

  // Watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("xor_checked_frame_deframer test failed");
      $finish;
    end
  end

  // Main sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // forwarding off after reset: good key frame gives nothing
    cfg_read_check();
    send_item(1'b0, START_CODE);
    send_item(1'b0, 8'h12);
    send_item(1'b0, 8'h34);
    send_item(1'b0, 8'h26);
    send_item(1'b0, STOP_CODE);
    settle();
    cfg_write(32'd1);
    cfg_read_check();

    // control codes, timeout, unknown byte at idle
    send_item(1'b0, ALIVE_CODE);
    send_item(1'b0, TWO_PLAYER_CODE);
    send_item(1'b0, SELECT_JOY_CODE);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    // key frame carrying control codes as payload
    send_item(1'b0, START_CODE);
    send_item(1'b0, ALIVE_CODE);
    send_item(1'b0, TWO_PLAYER_CODE);
    send_item(1'b0, 8'h01);
    send_item(1'b0, STOP_CODE);
    // bad check
    send_item(1'b0, START_CODE);
    send_item(1'b0, 8'h5A);
    send_item(1'b0, 8'hA5);
    send_item(1'b0, 8'h00);
    send_item(1'b0, STOP_CODE);
    // timeout inside a frame keeps the position; missing stop byte
    send_item(1'b0, START_CODE);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'h02);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h03);
    send_item(1'b0, 8'h54);

    random_phase(70);
    settle();

    // forwarding off, no idling on either side
    cfg_write(32'd0);
    cfg_read_check();
    settings_used++;
    no_idle = 1'b1;
    random_phase(70);
    settle();
    no_idle = 1'b0;

    // forwarding on through an all-ones write
    cfg_write(32'hFFFF_FFFF);
    cfg_read_check();
    settings_used++;
    random_phase(70);
    settle();

    $display("Covered %0d items and %0d results over %0d forwarding settings.",
             tracker.items_seen, tracker.results_seen, settings_used);
    if (tracker.errors == 0 && tracker.awaited.size() == 0)
      $display("xor_checked_frame_deframer test passed");
    else
      $display("xor_checked_frame_deframer test failed");
    $finish;
  end

endmodule

// ===== xor_checked_frame_deframer.f =====
design/xcfd_pkg.sv
design/xcfd_front.sv
design/xcfd_cmd_queue.sv
design/xcfd_back.sv
design/xor_checked_frame_deframer.sv
tb/xor_checked_frame_deframer_test.sv
